[rtl/dnh_pkg.sv]
// ---------------------------------------------------------------------------
// dnh_pkg: shared types, constants and functions of the name hash
// Holds the CRC32C byte step, the separator test and the item record
// that travels from the input register to the hash core.
// ---------------------------------------------------------------------------
package dnh_pkg;

    localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] KEY_HIGH_BIT = 32'h8000_0000;
    localparam logic [31:0] KEY_MID_MASK = 32'hFFFF_0000;
    localparam logic [31:0] KEY_LOW_MARK = 32'h0000_8000;

    localparam logic [7:0] SEP_DOT   = 8'h2E;
    localparam logic [7:0] SEP_DASH  = 8'h2D;
    localparam logic [7:0] SEP_UNDER = 8'h5F;
    localparam logic [7:0] SEP_TILDE = 8'h7E;

    // One input item as held in the input register.
    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
        logic       no_byte;
    } t_item;

    // One byte through the reflected CRC32C register, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'h00_0000, data};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    // True for the bytes that split the name into segments.
    function automatic logic is_separator(input logic [7:0] data);
        return (data == SEP_DOT) || (data == SEP_DASH) ||
               (data == SEP_UNDER) || (data == SEP_TILDE);
    endfunction

endpackage

[rtl/dnh_in_reg.sv]
// ---------------------------------------------------------------------------
// dnh_in_reg: input register of the name hash
// Captures one byte item per transfer and holds it until the core
// takes it; a new item may load in the same cycle the old one leaves.
// ---------------------------------------------------------------------------
module dnh_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_name_byte,
    input  logic           i_last_byte,
    input  logic           i_no_byte,
    input  logic           i_take,
    output logic           o_item_valid,
    output dnh_pkg::t_item o_item
);

    logic           r_valid;
    dnh_pkg::t_item r_item;
    logic           load;

    // The register is free when empty or when its item moves on this cycle.
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= '{name_byte: i_name_byte, last_byte: i_last_byte,
                        no_byte: i_no_byte};
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

[rtl/dnh_core.sv]
// ---------------------------------------------------------------------------
// dnh_core: running CRC state and key formation
// Absorbs one byte per cycle while stepped into the segment and whole-name CRCs,
// folds finished segments into the sum and forms the key on the last byte.
// ---------------------------------------------------------------------------
module dnh_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  dnh_pkg::t_item i_item,
    output logic           o_key_valid,
    output logic [63:0]    o_key
);

    logic [31:0] r_seg_crc;
    logic        r_seg_nonempty;
    logic [31:0] r_seg_sum;
    logic [31:0] r_whole_crc;

    logic [31:0] n_seg_crc;
    logic        n_seg_nonempty;
    logic [31:0] n_seg_sum;
    logic [31:0] n_whole_crc;

    logic        active;
    logic        sep;
    logic [31:0] seg_after;
    logic        ne_after;
    logic [31:0] addend;
    logic [31:0] sum_out;
    logic [31:0] whole_fin;

    // Per-byte updates; a separator closes the segment, other bytes extend it.
    always_comb begin
        active      = !i_item.no_byte;
        sep         = dnh_pkg::is_separator(i_item.name_byte);
        n_whole_crc = active ? dnh_pkg::crc_byte(r_whole_crc, i_item.name_byte)
                             : r_whole_crc;
        seg_after   = r_seg_crc;
        ne_after    = r_seg_nonempty;
        addend      = 32'h0000_0000;
        if (active && sep) begin
            seg_after = dnh_pkg::CRC_INIT;
            ne_after  = 1'b0;
            if (r_seg_nonempty) begin
                addend = ~r_seg_crc;
            end
        end else if (active) begin
            seg_after = dnh_pkg::crc_byte(r_seg_crc, i_item.name_byte);
            ne_after  = 1'b1;
        end
        // A separator already closed the segment, so at most one add is needed.
        if (i_item.last_byte && ne_after) begin
            addend = ~seg_after;
        end
        sum_out   = r_seg_sum + addend;
        whole_fin = ~n_whole_crc;

        // The last item returns all state to its starting values.
        if (i_item.last_byte) begin
            n_seg_crc      = dnh_pkg::CRC_INIT;
            n_seg_nonempty = 1'b0;
            n_seg_sum      = 32'h0000_0000;
            n_whole_crc    = dnh_pkg::CRC_INIT;
        end else begin
            n_seg_crc      = seg_after;
            n_seg_nonempty = ne_after;
            n_seg_sum      = sum_out;
        end
    end

    // Key assembly for the result register.
    assign o_key_valid = i_step && i_item.last_byte;
    assign o_key = {sum_out | dnh_pkg::KEY_HIGH_BIT,
                    ((whole_fin ^ (whole_fin << 16)) & dnh_pkg::KEY_MID_MASK)
                    | dnh_pkg::KEY_LOW_MARK};

    // State registers advance once per item taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_crc      <= dnh_pkg::CRC_INIT;
            r_seg_nonempty <= 1'b0;
            r_seg_sum      <= 32'h0000_0000;
            r_whole_crc    <= dnh_pkg::CRC_INIT;
        end else if (i_step) begin
            r_seg_crc      <= n_seg_crc;
            r_seg_nonempty <= n_seg_nonempty;
            r_seg_sum      <= n_seg_sum;
            r_whole_crc    <= n_whole_crc;
        end
    end

endmodule

[rtl/directory_name_hash.sv]
// ---------------------------------------------------------------------------
// directory_name_hash: segmented CRC32C directory key generator
// Takes a file name one byte per transfer and returns a 64-bit key
// after the byte marked last.
// ---------------------------------------------------------------------------
// The block accepts one byte per cycle: an input register feeds a
// combinational CRC32C byte step and segment add, and a result register
// holds the key, so a byte is taken in every cycle in which the result
// side is not stalled with a key waiting. The last byte is held in the
// input register, and the key it completes is captured in the result
// register and shown from there. An item with the no-byte flag set and
// not marked last is ignored; with last set it closes the name, so an
// empty name gives 0x80000000_00008000.
module directory_name_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_name_byte,
    input  logic        i_last_byte,
    input  logic        i_no_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_key
);

    logic           item_valid;
    dnh_pkg::t_item item;
    logic           step;
    logic           key_valid;
    logic [63:0]    key;
    logic           r_out_valid;
    logic [63:0]    r_out_key;

    // The core steps when an item is held and the result register can take.
    assign step = item_valid && (!r_out_valid || !i_stall);

    dnh_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_name_byte  (i_name_byte),
        .i_last_byte  (i_last_byte),
        .i_no_byte    (i_no_byte),
        .i_take       (step),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    dnh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (item),
        .o_key_valid (key_valid),
        .o_key       (key)
    );

    // Result register: cleared once its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (key_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_valid) begin
            r_out_key <= key;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_hash_key = r_out_key;

endmodule
